// File: sv/hrhp_pkg.sv
// Package: types, constants and keyword tables for the HTTP request header parser.
package hrhp_pkg;

  localparam int unsigned MAX_REQUEST_BYTES_DEF = 2048;
  localparam int unsigned CNT_W = 12;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_BAD  = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    T_METHOD  = 5'd0,
    T_GAP1    = 5'd1,
    T_PREFIX  = 5'd2,
    T_HOST    = 5'd3,
    T_PATH    = 5'd4,
    T_GAP2    = 5'd5,
    T_VERSION = 5'd6,
    T_HSTART  = 5'd7,
    T_HNAME   = 5'd8,
    T_HGAP    = 5'd9,
    T_HCONN   = 5'd10,
    T_HLEN    = 5'd11,
    T_HSKIP   = 5'd12
  } token_t;

  typedef enum logic [1:0] {
    HK_UNKNOWN = 2'd0,
    HK_CONN    = 2'd1,
    HK_CLEN    = 2'd2,
    HK_UNDEC   = 2'd3
  } hdr_kind_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_BAD        = 2'd2
  } status_t;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SL  = 8'h2F;

  typedef struct packed {
    phase_t      phase;
    token_t      tok;
    logic [3:0]  midx;
    logic        cr_pend;
    logic [CNT_W-1:0] bcnt;
    hdr_kind_t   hkind;
    logic        keep;
    logic [31:0] len;
    logic [CNT_W-1:0] pstart;
    logic [CNT_W-1:0] pend;
    logic [31:0] body;
  } pstate_t;

  typedef struct packed {
    status_t     status;
    logic        keep_alive;
    logic [31:0] clen;
    logic [11:0] url_start;
    logic [11:0] url_end;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CH_SP) || (b == CH_TAB);
  endfunction

  // Keyword tables, lower case, indexed by character position.
  function automatic logic [7:0] kw_get(input logic [3:0] i);
    case (i)
      4'd0: kw_get = "g";
      4'd1: kw_get = "e";
      4'd2: kw_get = "t";
      default: kw_get = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_ver(input logic [3:0] i);
    case (i)
      4'd0: kw_ver = "h";
      4'd1: kw_ver = "t";
      4'd2: kw_ver = "t";
      4'd3: kw_ver = "p";
      4'd4: kw_ver = "/";
      4'd5: kw_ver = "1";
      4'd6: kw_ver = ".";
      4'd7: kw_ver = "1";
      default: kw_ver = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_abs(input logic [3:0] i);
    case (i)
      4'd0: kw_abs = "h";
      4'd1: kw_abs = "t";
      4'd2: kw_abs = "t";
      4'd3: kw_abs = "p";
      4'd4: kw_abs = ":";
      4'd5: kw_abs = "/";
      4'd6: kw_abs = "/";
      default: kw_abs = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_conn(input logic [3:0] i);
    case (i)
      4'd0:  kw_conn = "c";
      4'd1:  kw_conn = "o";
      4'd2:  kw_conn = "n";
      4'd3:  kw_conn = "n";
      4'd4:  kw_conn = "e";
      4'd5:  kw_conn = "c";
      4'd6:  kw_conn = "t";
      4'd7:  kw_conn = "i";
      4'd8:  kw_conn = "o";
      4'd9:  kw_conn = "n";
      4'd10: kw_conn = ":";
      default: kw_conn = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_clen(input logic [3:0] i);
    case (i)
      4'd0:  kw_clen = "c";
      4'd1:  kw_clen = "o";
      4'd2:  kw_clen = "n";
      4'd3:  kw_clen = "t";
      4'd4:  kw_clen = "e";
      4'd5:  kw_clen = "n";
      4'd6:  kw_clen = "t";
      4'd7:  kw_clen = "-";
      4'd8:  kw_clen = "l";
      4'd9:  kw_clen = "e";
      4'd10: kw_clen = "n";
      4'd11: kw_clen = "g";
      4'd12: kw_clen = "t";
      4'd13: kw_clen = "h";
      4'd14: kw_clen = ":";
      default: kw_clen = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_keep(input logic [3:0] i);
    case (i)
      4'd0: kw_keep = "k";
      4'd1: kw_keep = "e";
      4'd2: kw_keep = "e";
      4'd3: kw_keep = "p";
      4'd4: kw_keep = "-";
      4'd5: kw_keep = "a";
      4'd6: kw_keep = "l";
      4'd7: kw_keep = "i";
      4'd8: kw_keep = "v";
      4'd9: kw_keep = "e";
      default: kw_keep = 8'h00;
    endcase
  endfunction

endpackage

// File: sv/hrhp_stream_if.sv
// Interface: valid/ready stream channel with a generic payload.
interface hrhp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/http_request_header_parser_core.sv
// Top level: HTTP request header parser core with stream channels.
// Takes one request byte per transfer and returns one result per byte, at one
// byte per clock: the parse state sits in one register and the next state
// and the result for a byte are formed in a single combinational pass, with
// the result held in an output register. A byte is taken whenever the output
// register is empty or being drained in the same cycle, so each result is
// offered in the cycle after its byte and back-to-back transfers run at full
// rate. A bad request sticks at status 2 until reset; a completed request
// clears the state and the next byte begins a new request. Head bytes beyond
// MAX_REQUEST_BYTES make the request bad.
module http_request_header_parser_core
  import hrhp_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
  input logic clk,
  input logic rst_n,
  hrhp_stream_if.sink   in_ch,
  hrhp_stream_if.source out_ch
);

  pstate_t    st_r;
  pstate_t    st_nxt;
  result_t    res_nxt;
  result_t    res_r;
  logic       vld_r;
  logic       take;

  // Accept when the output slot is free or being emptied this cycle.
  assign in_ch.ready = !vld_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  hrhp_step #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_step (
    .cur       (st_r),
    .data_byte (in_ch.data),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      if (take) st_r <= st_nxt;
      if (take) vld_r <= 1'b1;
      else if (out_ch.ready) vld_r <= 1'b0;
    end
  end

  // Hold the result until its transfer.
  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_ch.valid = vld_r;
  assign out_ch.data  = res_r;

endmodule

// File: sv/hrhp_step.sv
// Combinational next-state logic for one byte of the request stream.
module hrhp_step
  import hrhp_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
  input  pstate_t    cur,
  input  logic [7:0] data_byte,
  output pstate_t    nxt,
  output result_t    res
);

  logic [7:0]  lb;
  logic        bl;
  logic [3:0]  mi;
  logic [35:0] prod;
  logic [31:0] sat;
  status_t     st;
  pstate_t     s;
  token_t      tk;
  hdr_kind_t   hk;

  assign lb = to_lower(data_byte);
  assign bl = is_blank(data_byte);
  // Saturating accumulate of one decimal digit: len*10 = len*8 + len*2.
  assign prod = {1'b0, cur.len, 3'b000} + {3'b000, cur.len, 1'b0}
              + {32'd0, data_byte[3:0] - 4'd0};
  assign sat  = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];

  always_comb begin
    s  = cur;
    st = ST_INCOMPLETE;
    tk = cur.tok;
    hk = cur.hkind;
    mi = cur.midx;
    if (cur.phase == PH_BAD) begin
      st = ST_BAD;
    end else if (cur.phase == PH_BODY) begin
      s.body = cur.body + 32'd1;
      if (s.body >= cur.len) st = ST_COMPLETE;
    end else if ({20'd0, cur.bcnt} >= 32'(MAX_REQUEST_BYTES)) begin
      s.phase = PH_BAD;
      st      = ST_BAD;
    end else begin
      s.bcnt = cur.bcnt + 1'b1;
      if (cur.cr_pend) begin
        s.cr_pend = 1'b0;
        if (data_byte != CH_LF) begin
          s.phase = PH_BAD;
          st      = ST_BAD;
        end else if (cur.phase == PH_LINE) begin
          if (cur.tok == T_VERSION && cur.midx == 4'd8) begin
            s.phase = PH_HEAD;
            s.tok   = T_HSTART;
            s.midx  = '0;
          end else begin
            s.phase = PH_BAD;
            st      = ST_BAD;
          end
        end else if (cur.tok == T_HSTART) begin
          if (cur.len != 32'd0) begin
            s.phase = PH_BODY;
            s.body  = '0;
          end else begin
            st = ST_COMPLETE;
          end
        end else begin
          if (cur.tok == T_HCONN && cur.midx == 4'd10) s.keep = 1'b1;
          s.tok   = T_HSTART;
          s.midx  = '0;
          s.hkind = HK_UNKNOWN;
        end
      end else if (data_byte == CH_CR) begin
        s.cr_pend = 1'b1;
      end else begin
        // Resolve states that hand the byte straight on.
        if (tk == T_GAP2 && !bl) begin
          tk = T_VERSION;
          mi = '0;
        end
        if (tk == T_HSTART) begin
          tk = T_HNAME;
          hk = HK_UNDEC;
          mi = '0;
        end
        if (tk == T_HGAP && !bl) tk = (hk == HK_CONN) ? T_HCONN : T_HLEN;
        s.tok  = tk;
        s.midx = mi;
        s.hkind = hk;
        case (tk)
          T_METHOD: begin
            if (bl) begin
              if (mi == 4'd3) begin
                s.tok  = T_GAP1;
                s.midx = '0;
              end else s.phase = PH_BAD;
            end else if (mi < 4'd3 && lb == kw_get(mi)) s.midx = mi + 4'd1;
            else s.phase = PH_BAD;
          end
          T_GAP1: begin
            if (!bl) begin
              if (data_byte == CH_SL) begin
                s.pstart = cur.bcnt;
                s.tok    = T_PATH;
              end else if (lb == "h") begin
                s.tok  = T_PREFIX;
                s.midx = 4'd1;
              end else s.phase = PH_BAD;
            end
          end
          T_PREFIX: begin
            if (bl || !(mi < 4'd7 && lb == kw_abs(mi))) s.phase = PH_BAD;
            else if (mi == 4'd6) begin
              s.tok  = T_HOST;
              s.midx = '0;
            end else s.midx = mi + 4'd1;
          end
          T_HOST: begin
            if (bl) s.phase = PH_BAD;
            else if (data_byte == CH_SL) begin
              s.pstart = cur.bcnt;
              s.tok    = T_PATH;
            end
          end
          T_PATH: begin
            if (bl) begin
              s.pend = cur.bcnt;
              s.tok  = T_GAP2;
            end
          end
          T_VERSION: begin
            if (bl || !(mi < 4'd8 && lb == kw_ver(mi))) s.phase = PH_BAD;
            else s.midx = mi + 4'd1;
          end
          T_HNAME: begin
            if (hk == HK_UNDEC && mi == 4'd3) begin
              hk      = (lb == "t") ? HK_CLEN : HK_CONN;
              s.hkind = hk;
            end
            if (hk == HK_CLEN) begin
              if (!(mi < 4'd15 && lb == kw_clen(mi))) s.tok = T_HSKIP;
              else if (mi == 4'd14) begin
                s.tok  = T_HGAP;
                s.midx = '0;
                s.len  = '0;
              end else s.midx = mi + 4'd1;
            end else begin
              if (!(mi < 4'd11 && lb == kw_conn(mi))) s.tok = T_HSKIP;
              else if (mi == 4'd10) begin
                s.tok  = T_HGAP;
                s.midx = '0;
              end else s.midx = mi + 4'd1;
            end
          end
          T_HCONN: begin
            if (mi < 4'd10 && lb == kw_keep(mi)) s.midx = mi + 4'd1;
            else s.tok = T_HSKIP;
          end
          T_HLEN: begin
            if (data_byte >= "0" && data_byte <= "9") s.len = sat;
            else s.tok = T_HSKIP;
          end
          default: begin
          end
        endcase
        if (s.phase == PH_BAD) st = ST_BAD;
      end
    end
    res.status     = st;
    res.keep_alive = s.keep;
    res.clen       = s.len;
    res.url_start  = s.pstart;
    res.url_end    = s.pend;
    nxt = s;
    if (st == ST_COMPLETE) nxt = '0;
  end

endmodule
